// ===== rtl/wsfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfd_pkg
// Types, opcodes and result codes shared by the WebSocket frame decoder.
// ----------------------------------------------------------------------------
package wsfd_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 64;
    localparam int REM_W   = 32;
    localparam int MAX_W   = 32;
    localparam int EXTC_W  = 4;

    // Reset value of the payload limit: 4 MiB
    localparam logic [MAX_W-1:0] MAX_LEN_RST = MAX_W'(4 * 1024 * 1024);

    // Frame opcodes
    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    // Second header byte length codes
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    localparam logic [EXTC_W-1:0] EXT16_BYTES = EXTC_W'(2);
    localparam logic [EXTC_W-1:0] EXT64_BYTES = EXTC_W'(8);
    localparam logic [REM_W-1:0]  PING_MAX_LEN = REM_W'(125);

    // Parser phase
    typedef enum logic [1:0] {
        PH_HDR0 = 2'd0,
        PH_HDR1 = 2'd1,
        PH_EXT  = 2'd2,
        PH_PAY  = 2'd3
    } phase_t;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_MSG_BYTE   = 3'd0,
        KIND_PING_BYTE  = 3'd1,
        KIND_EMPTY_MSG  = 3'd2,
        KIND_EMPTY_PING = 3'd3,
        KIND_CLOSE      = 3'd4,
        KIND_ERROR      = 3'd5
    } kind_t;

    // Error codes
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_MASKED    = 3'd1,
        ERR_ABSURD    = 3'd2,
        ERR_TOO_LARGE = 3'd3,
        ERR_BAD_PING  = 3'd4,
        ERR_STRAY     = 3'd5,
        ERR_UNKNOWN   = 3'd6,
        ERR_NESTED    = 3'd7
    } err_t;

    // One result item
    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] payload_byte;
        logic              last;
        logic [1:0]        message_type;
        err_t              error_code;
    } res_t;

    // Handshake between the stages
    typedef struct packed {
        logic step;   // input stage hands a byte to the parser this cycle
    } stage_ctl_t;

endpackage

// ===== rtl/wsfd_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfd_in_stage
// Input register for received bytes; releases one byte per parser step.
// ----------------------------------------------------------------------------
module wsfd_in_stage
    import wsfd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    input  logic              room_i,
    output stage_ctl_t        ctl_o,
    output logic [BYTE_W-1:0] byte_o
);

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg,  in_byte_next;
    logic              step;

    // Byte moves on when the output side has room
    assign step     = in_valid_reg && room_i;
    assign s_tready = !in_valid_reg || step;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        in_byte_reg <= in_byte_next;
    end

    assign ctl_o.step = step;
    assign byte_o     = in_byte_reg;

endmodule

// ===== rtl/wsfd_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfd_parser
// Frame header state machine, header checks and payload byte tagging.
// ----------------------------------------------------------------------------
module wsfd_parser
    import wsfd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  stage_ctl_t        ctl_i,
    input  logic [BYTE_W-1:0] byte_i,
    input  logic [MAX_W-1:0]  max_len_i,
    output logic              res_valid_o,
    output res_t              res_o
);

    phase_t            phase_reg,     phase_next;
    logic              halted_reg,    halted_next;
    logic [3:0]        opcode_reg,    opcode_next;
    logic              final_reg,     final_next;
    logic [LEN_W-1:0]  acc_reg,       acc_next;
    logic [EXTC_W-1:0] ext_left_reg,  ext_left_next;
    logic [REM_W-1:0]  rem_reg,       rem_next;
    logic              in_frag_reg,   in_frag_next;
    logic [1:0]        first_mt_reg,  first_mt_next;

    logic             live;
    logic             is_ext_len;
    logic             hdr_end;
    logic [LEN_W-1:0] len_new;
    logic             len_zero;
    logic             too_large;
    logic             rem_last;

    err_t       hd_err;
    logic       hd_close;
    logic       hd_empty_ping;
    logic       hd_data_ok;
    logic [1:0] hd_mtype;
    logic       hd_fail;

    assign live       = ctl_i.step && !halted_reg;
    assign is_ext_len = (byte_i[6:0] == LEN7_EXT16) || (byte_i[6:0] == LEN7_EXT64);
    assign rem_last   = (rem_reg == REM_W'(1));

    // Length as it stands after this byte
    assign len_new = (phase_reg == PH_EXT) ? {acc_reg[LEN_W-BYTE_W-1:0], byte_i}
                                           : {{(LEN_W-7){1'b0}}, byte_i[6:0]};

    assign hdr_end = ((phase_reg == PH_HDR1) && !byte_i[7] && !is_ext_len) ||
                     ((phase_reg == PH_EXT) && (ext_left_reg == EXTC_W'(1)));

    assign len_zero  = (len_new == '0);
    assign too_large = (|len_new[LEN_W-1:REM_W]) || (len_new[REM_W-1:0] > max_len_i);

    // Header checks, in priority order
    always_comb begin
        hd_err        = ERR_NONE;
        hd_close      = 1'b0;
        hd_empty_ping = 1'b0;
        hd_data_ok    = 1'b0;
        hd_mtype      = first_mt_reg;
        if (len_new[LEN_W-1]) begin
            hd_err = ERR_ABSURD;
        end else if (too_large) begin
            hd_err = ERR_TOO_LARGE;
        end else begin
            case (opcode_reg)
                OP_CLOSE: begin
                    hd_close = 1'b1;
                end
                OP_PING: begin
                    if (!final_reg || (len_new[REM_W-1:0] > PING_MAX_LEN)) begin
                        hd_err = ERR_BAD_PING;
                    end else begin
                        hd_empty_ping = len_zero;
                    end
                end
                OP_PONG: begin
                    hd_err = ERR_NONE;
                end
                OP_CONT: begin
                    if (!in_frag_reg) begin
                        hd_err = ERR_STRAY;
                    end else begin
                        hd_data_ok = 1'b1;
                    end
                end
                OP_TEXT, OP_BIN: begin
                    if (in_frag_reg) begin
                        hd_err = ERR_NESTED;
                    end else begin
                        hd_data_ok = 1'b1;
                        hd_mtype   = opcode_reg[1:0];
                    end
                end
                default: begin
                    hd_err = ERR_UNKNOWN;
                end
            endcase
        end
    end

    assign hd_fail = (hd_err != ERR_NONE);

    // Next state
    always_comb begin
        phase_next    = phase_reg;
        halted_next   = halted_reg;
        opcode_next   = opcode_reg;
        final_next    = final_reg;
        acc_next      = acc_reg;
        ext_left_next = ext_left_reg;
        rem_next      = rem_reg;
        in_frag_next  = in_frag_reg;
        first_mt_next = first_mt_reg;
        if (live) begin
            case (phase_reg)
                PH_HDR0: begin
                    final_next  = byte_i[7];
                    opcode_next = byte_i[3:0];
                    phase_next  = PH_HDR1;
                end
                PH_HDR1: begin
                    if (byte_i[7]) begin
                        halted_next = 1'b1;
                        phase_next  = PH_HDR0;
                    end else if (is_ext_len) begin
                        acc_next      = '0;
                        ext_left_next = (byte_i[6:0] == LEN7_EXT16) ? EXT16_BYTES
                                                                    : EXT64_BYTES;
                        phase_next    = PH_EXT;
                    end else begin
                        acc_next = len_new;
                    end
                end
                PH_EXT: begin
                    acc_next      = len_new;
                    ext_left_next = ext_left_reg - EXTC_W'(1);
                end
                PH_PAY: begin
                    rem_next = rem_reg - REM_W'(1);
                    if (rem_last) begin
                        phase_next = PH_HDR0;
                    end
                end
                default: begin
                    phase_next = PH_HDR0;
                end
            endcase

            // Header complete: commit the frame or halt
            if (hdr_end) begin
                if (hd_fail || hd_close) begin
                    halted_next = 1'b1;
                    phase_next  = PH_HDR0;
                end else begin
                    rem_next   = len_new[REM_W-1:0];
                    phase_next = len_zero ? PH_HDR0 : PH_PAY;
                    if (hd_data_ok) begin
                        in_frag_next  = !final_reg;
                        first_mt_next = hd_mtype;
                    end
                end
            end
        end
    end

    // Result of this byte
    always_comb begin
        res_valid_o        = 1'b0;
        res_o.kind         = KIND_MSG_BYTE;
        res_o.payload_byte = '0;
        res_o.last         = 1'b0;
        res_o.message_type = 2'd0;
        res_o.error_code   = ERR_NONE;
        if (live) begin
            case (phase_reg)
                PH_HDR1, PH_EXT: begin
                    if ((phase_reg == PH_HDR1) && byte_i[7]) begin
                        res_valid_o      = 1'b1;
                        res_o.kind       = KIND_ERROR;
                        res_o.error_code = ERR_MASKED;
                    end else if (hdr_end) begin
                        if (hd_fail) begin
                            res_valid_o      = 1'b1;
                            res_o.kind       = KIND_ERROR;
                            res_o.error_code = hd_err;
                        end else if (hd_close) begin
                            res_valid_o = 1'b1;
                            res_o.kind  = KIND_CLOSE;
                        end else if (hd_empty_ping) begin
                            res_valid_o = 1'b1;
                            res_o.kind  = KIND_EMPTY_PING;
                            res_o.last  = 1'b1;
                        end else if (hd_data_ok && len_zero && final_reg) begin
                            res_valid_o        = 1'b1;
                            res_o.kind         = KIND_EMPTY_MSG;
                            res_o.last         = 1'b1;
                            res_o.message_type = hd_mtype;
                        end
                    end
                end
                PH_PAY: begin
                    if (opcode_reg == OP_PING) begin
                        res_valid_o        = 1'b1;
                        res_o.kind         = KIND_PING_BYTE;
                        res_o.payload_byte = byte_i;
                        res_o.last         = rem_last;
                    end else if (opcode_reg != OP_PONG) begin
                        res_valid_o        = 1'b1;
                        res_o.kind         = KIND_MSG_BYTE;
                        res_o.payload_byte = byte_i;
                        res_o.last         = rem_last && final_reg;
                        res_o.message_type = first_mt_reg;
                    end
                end
                default: begin
                    res_valid_o = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HDR0;
            halted_reg   <= 1'b0;
            ext_left_reg <= '0;
            in_frag_reg  <= 1'b0;
            first_mt_reg <= 2'd0;
            final_reg    <= 1'b0;
            opcode_reg   <= OP_CONT;
        end else begin
            phase_reg    <= phase_next;
            halted_reg   <= halted_next;
            ext_left_reg <= ext_left_next;
            in_frag_reg  <= in_frag_next;
            first_mt_reg <= first_mt_next;
            final_reg    <= final_next;
            opcode_reg   <= opcode_next;
        end
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

endmodule

// ===== rtl/wsfd_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfd_out_stage
// Result register driving the master-side stream.
// ----------------------------------------------------------------------------
module wsfd_out_stage
    import wsfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step_i,
    input  logic        res_valid_i,
    input  res_t        res_i,
    output logic        room_o,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] payload_byte, [10:8] error_code, rest zero
    output logic        m_tlast,
    output logic [4:0]  m_tuser    // [2:0] kind, [4:3] message_type
);

    logic out_valid_reg, out_valid_next;
    res_t out_res_reg,   out_res_next;

    // Room when empty or when the held result leaves this cycle
    assign room_o = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (step_i) begin
            out_valid_next = res_valid_i;
            out_res_next   = res_i;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_res_reg.error_code, out_res_reg.payload_byte};
    assign m_tlast  = out_res_reg.last;
    assign m_tuser  = {out_res_reg.message_type, out_res_reg.kind};

endmodule

// ===== rtl/websocket_frame_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_decoder
// Server-to-client WebSocket frame parser, one byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one received byte per transaction in s_tdata[7:0].
//   m_ channel: zero or one result per input byte. tuser carries the kind and
//   message type, tdata the payload byte and error code, tlast marks the
//   final byte or end marker of a message or ping.
//   cfg channel: writes max_payload_len; always ready, write only when idle.
// Path: a byte passes the byte register, the parser logic and the result
//   register before its result is offered on the m_ channel.
// Throughput: one byte per cycle, sustained while m_tready stays high. The
//   header state machine updates once per byte, so bytes follow back to back.
// Reset: aresetn low clears the stages and the parser to expect a first
//   header byte; max_payload_len returns to 4 MiB.
// Stall: with m_tready low the result register holds; the byte register
//   still takes one further byte, then s_tready drops until room frees up.
// After a close event or any error the block swallows all bytes until reset.
// ----------------------------------------------------------------------------
module websocket_frame_decoder
    import wsfd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] rx_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [7:0] payload_byte, [10:8] error_code
    output logic              m_tlast,   // last
    output logic [4:0]        m_tuser,   // [2:0] kind, [4:3] message_type
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [MAX_W-1:0]  cfg_data   // max_payload_len
);

    logic [MAX_W-1:0]  max_len_reg, max_len_next;
    stage_ctl_t        ctl;
    logic [BYTE_W-1:0] in_byte;
    logic              room;
    logic              res_valid;
    res_t              res;

    // Payload limit register
    assign cfg_ready    = 1'b1;
    assign max_len_next = (cfg_valid && cfg_ready) ? cfg_data : max_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RST;
        end else begin
            max_len_reg <= max_len_next;
        end
    end

    wsfd_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .room_i   (room),
        .ctl_o    (ctl),
        .byte_o   (in_byte)
    );

    wsfd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl_i       (ctl),
        .byte_i      (in_byte),
        .max_len_i   (max_len_reg),
        .res_valid_o (res_valid),
        .res_o       (res)
    );

    wsfd_out_stage u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_i      (ctl.step),
        .res_valid_i (res_valid),
        .res_i       (res),
        .room_o      (room),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

// ===== rtl/wsfd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfd_checker
// Port-level checks on the result stream of the frame decoder.
// ----------------------------------------------------------------------------
module wsfd_checker
    import wsfd_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic [4:0]  m_tuser
);

    // Stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Error results always carry a code
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[2:0] == KIND_ERROR) |-> (m_tdata[10:8] != ERR_NONE))
        else $error("error result without code");

    // Non-error results carry no code
    a_no_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[2:0] != KIND_ERROR) |-> (m_tdata[10:8] == ERR_NONE))
        else $error("code on non-error result");

    // Empty markers end their message or ping
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tuser[2:0] == KIND_EMPTY_MSG) ||
                     (m_tuser[2:0] == KIND_EMPTY_PING)) |-> m_tlast)
        else $error("empty marker without tlast");

    // Only byte kinds carry a payload byte
    a_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[2:0] != KIND_MSG_BYTE) &&
        (m_tuser[2:0] != KIND_PING_BYTE) |-> (m_tdata[7:0] == 8'd0))
        else $error("payload byte on event result");

endmodule

bind websocket_frame_decoder wsfd_checker u_wsfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
